// File: sv/dlp_pkg.sv
// Shared types and constants for the dump line packer.
package dlp_pkg;

    localparam int ADDR_W      = 32;
    localparam int CNT_W       = 25;
    localparam int SIZE_WORD   = 4;
    localparam int TAIL_W      = SIZE_WORD * 8;
    localparam int MAX_RESULTS = 8;
    localparam int BEAT_DATA_W = 64;
    localparam int M_TDATA_W   = 104;
    localparam logic [TAIL_W-1:0] TAIL_TRUNC = 32'hFFFF_FFFF;
    localparam logic [CNT_W-1:0]  SIZE_RESET = 25'd131072;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_DATA  = 2'd1,
        REQ_END   = 2'd2
    } dlp_req_t;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2
    } dlp_size_t;

    typedef enum logic [0:0] {
        CFG_BASE = 1'b0,
        CFG_SIZE = 1'b1
    } dlp_cfg_t;

    // One or two lines handed from the packer to the beat sequencer.
    typedef struct packed {
        logic              valid;
        logic [1:0]        lines;
        logic [ADDR_W-1:0] addr0;
        logic [ADDR_W-1:0] addr1;
    } dlp_load_t;

endpackage

// File: sv/dlp_line_emit.sv
// Beat sequencer: holds up to two lines and sends them out as 64-bit beats.
module dlp_line_emit import dlp_pkg::*; #(
    parameter int LINE_BYTES = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dlp_load_t               ld,
    input  logic [LINE_BYTES*8-1:0] ld_line0,
    input  logic [LINE_BYTES*8-1:0] ld_line1,
    output logic                    busy,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_W-1:0]    m_tdata,
    output logic                    m_tlast
);

    localparam int LINE_W = LINE_BYTES * 8;
    localparam int BEATS  = LINE_BYTES / 8;
    localparam int BEAT_W = (BEATS > 1) ? $clog2(BEATS) : 1;
    localparam int TOT_W  = $clog2(MAX_RESULTS);

    logic                pend_active_reg;
    logic [1:0]          pend_lines_reg;
    logic [ADDR_W-1:0]   pend_addr_reg [2];
    logic [LINE_W-1:0]   pend_line_reg [2];
    logic                line_sel_reg;
    logic [BEAT_W-1:0]   beat_reg;
    logic [TOT_W-1:0]    total_reg;

    logic                m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                m_last_reg;

    logic [LINE_W-1:0]      cur_line;
    logic [BEAT_DATA_W-1:0] beat_data;
    logic [ADDR_W-1:0]      beat_addr;
    logic                   last_line;
    logic                   beat_last;
    logic                   item_last;
    logic                   out_load;

    assign cur_line  = pend_line_reg[line_sel_reg];
    assign beat_data = cur_line[{beat_reg, 6'b000000} +: BEAT_DATA_W];
    assign beat_addr = pend_addr_reg[line_sel_reg] + ADDR_W'({beat_reg, 3'b000});
    assign last_line = (pend_lines_reg == 2'd1) || line_sel_reg;
    assign beat_last = (beat_reg == BEAT_W'(BEATS - 1));
    // Stop at the per-item beat limit even if a line is unfinished.
    assign item_last = (beat_last && last_line) || (total_reg == TOT_W'(MAX_RESULTS - 1));
    assign out_load  = pend_active_reg && (!m_valid_reg || m_tready);

    assign busy     = pend_active_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_active_reg <= 1'b0;
            line_sel_reg    <= 1'b0;
            beat_reg        <= '0;
            total_reg       <= '0;
        end else if (ld.valid) begin
            pend_active_reg <= 1'b1;
            line_sel_reg    <= 1'b0;
            beat_reg        <= '0;
            total_reg       <= '0;
        end else if (out_load) begin
            if (item_last) begin
                pend_active_reg <= 1'b0;
                line_sel_reg    <= 1'b0;
                beat_reg        <= '0;
                total_reg       <= '0;
            end else begin
                total_reg <= total_reg + TOT_W'(1);
                if (beat_last) begin
                    line_sel_reg <= 1'b1;
                    beat_reg     <= '0;
                end else begin
                    beat_reg <= beat_reg + BEAT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld.valid) begin
            pend_lines_reg   <= ld.lines;
            pend_addr_reg[0] <= ld.addr0;
            pend_addr_reg[1] <= ld.addr1;
            pend_line_reg[0] <= ld_line0;
            pend_line_reg[1] <= ld_line1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {6'b000000, 2'(beat_reg), beat_data, beat_addr};
            m_last_reg <= item_last;
        end
    end

    a_load_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ld.valid |-> !pend_active_reg)
        else $error("line load while sequencer busy");

    a_line_count: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_active_reg |-> (pend_lines_reg == 2'd1 || pend_lines_reg == 2'd2))
        else $error("pending line count out of range");

    a_second_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_active_reg && line_sel_reg) |-> pend_lines_reg == 2'd2)
        else $error("second line selected with one line pending");

endmodule

// File: sv/dump_line_packer_top.sv
// Top level of the dump line packer: input register, packing logic, beat sequencer.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    tuser: req_type, elem_size; tdata: elem_value;
//                                     tlast: region_end
//  m_       out  m_tvalid/m_tready    tdata: write_addr, write_data, beat_index;
//                                     tlast: run_last
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  An item is packed from the input register after it is taken; one that produces no line
//  frees the input register in the cycle it is packed, so such items enter every cycle.
//  An item that completes lines waits until the beat sequencer is empty, then hands over
//  one or two lines; they leave as LINE_BYTES/8 beats each, at most 8, one beat per cycle
//  while m_tready is high. A 32-byte line so leaves as 4 beats of 64-bit write_data.
//  Reset is synchronous; there is no clearing pass.
//  A stalled m_tready holds the current beat and backs up into s_tready.
module dump_line_packer_top import dlp_pkg::*; #(
    parameter int LINE_BYTES = 32   // 8..64, multiple of 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [31:0] elem_value
    input  logic [3:0]           s_tuser,   // [1:0] req_type, [3:2] elem_size
    input  logic                 s_tlast,   // region_end
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] write_addr, [95:32] write_data,
                                            // [97:96] beat_index, [103:98] zero
    output logic                 m_tlast,   // run_last
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [0:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int LINE_W = LINE_BYTES * 8;
    localparam int FILL_W = $clog2(LINE_BYTES + 1);

    function automatic logic [7:0] pick_byte(logic [31:0] v, logic [1:0] i);
        pick_byte = v[{i, 3'b000} +: 8];
    endfunction

    // configuration
    logic [ADDR_W-1:0] region_base_reg;
    logic [CNT_W-1:0]  region_size_reg;

    // input register
    logic       in_valid_reg;
    dlp_req_t   in_req_reg;
    dlp_size_t  in_size_reg;
    logic [31:0] in_value_reg;
    logic       in_adv;

    // packer state
    logic [LINE_W-1:0] line_reg, line_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0]  written_reg, written_next;
    logic              stopped_reg, stopped_next;

    logic [CNT_W:0]    stop_sum;
    logic              stop_hit;
    logic [2:0]        elem_cnt;
    logic [FILL_W:0]   fill_sum;
    logic [FILL_W:0]   fill_rem;
    logic [FILL_W:0]   wrap_cnt;
    logic [LINE_W-1:0] full_line;
    logic [LINE_W-1:0] wrap_line;

    dlp_load_t         ld_raw;
    dlp_load_t         ld;
    logic [LINE_W-1:0] ld_line0;
    logic [LINE_W-1:0] ld_line1;
    logic              emit_busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_base_reg <= '0;
            region_size_reg <= SIZE_RESET;
        end else if (cfg_valid) begin
            case (dlp_cfg_t'(cfg_index))
                CFG_BASE: region_base_reg <= cfg_data;
                CFG_SIZE: region_size_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // region_end does not affect packing; s_tlast is not stored
    assign in_adv   = in_valid_reg && (!ld_raw.valid || !emit_busy);
    assign s_tready = !in_valid_reg || in_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_req_reg   <= dlp_req_t'(s_tuser[1:0]);
            in_size_reg  <= dlp_size_t'(s_tuser[3:2]);
            in_value_reg <= s_tdata;
        end
    end

    assign stop_sum = {1'b0, written_reg} + (CNT_W+1)'(fill_reg) + (CNT_W+1)'(SIZE_WORD);
    assign stop_hit = stop_sum >= {1'b0, region_size_reg};

    always_comb begin
        case (in_size_reg)
            SZ_BYTE: elem_cnt = 3'd1;
            SZ_HALF: elem_cnt = 3'd2;
            SZ_WORD: elem_cnt = 3'd4;
            default: elem_cnt = 3'd0;
        endcase
    end

    assign fill_sum = {1'b0, fill_reg} + (FILL_W+1)'(elem_cnt);
    assign fill_rem = (FILL_W+1)'(LINE_BYTES) - {1'b0, fill_reg};
    assign wrap_cnt = fill_sum - (FILL_W+1)'(LINE_BYTES);

    // Place element bytes into the current line and, past its end, into the next one.
    always_comb begin : pack_bytes
        logic [FILL_W:0] kk;
        logic [FILL_W:0] off;
        logic [FILL_W:0] idx;
        full_line = line_reg;
        wrap_line = '0;
        for (int k = 0; k < LINE_BYTES; k++) begin
            kk  = (FILL_W+1)'(k);
            off = kk - {1'b0, fill_reg};
            idx = kk + fill_rem;
            if (kk >= {1'b0, fill_reg} && kk < fill_sum) begin
                full_line[8*k +: 8] = pick_byte(in_value_reg, off[1:0]);
            end
            if (kk < wrap_cnt) begin
                wrap_line[8*k +: 8] = pick_byte(in_value_reg, idx[1:0]);
            end
        end
    end

    always_comb begin : pack_ctrl
        logic [LINE_W-1:0] end_line1;
        logic [LINE_W-1:0] end_line2;
        logic [LINE_W-1:0] size_line;
        logic [FILL_W-1:0] end_fill1;
        logic [FILL_W-1:0] end_fill2;
        logic [CNT_W-1:0]  end_written;
        logic              emit_a;
        logic              emit_b;
        logic              close_part;
        logic [ADDR_W-1:0] line_addr;
        logic [ADDR_W-1:0] size_addr;

        line_next    = line_reg;
        fill_next    = fill_reg;
        written_next = written_reg;
        stopped_next = stopped_reg;
        ld_raw       = '0;
        ld_line0     = full_line;
        ld_line1     = '0;

        line_addr = region_base_reg + ADDR_W'(written_reg);
        size_addr = region_base_reg + ADDR_W'(region_size_reg) - ADDR_W'(LINE_BYTES);

        end_line1 = stop_hit ? {TAIL_TRUNC, line_reg[LINE_W-TAIL_W-1:0]} : line_reg;
        end_fill1 = stop_hit ? FILL_W'(LINE_BYTES) : fill_reg;
        emit_a    = (end_fill1 != '0);
        // Partial last line that reaches the region end carries the size word.
        close_part = (({1'b0, written_reg} + (CNT_W+1)'(LINE_BYTES)) >=
                      {1'b0, region_size_reg}) && (end_fill1 < FILL_W'(LINE_BYTES));
        end_line2 = close_part ? {TAIL_W'(written_reg), end_line1[LINE_W-TAIL_W-1:0]}
                               : end_line1;
        end_fill2 = close_part ? FILL_W'(LINE_BYTES) : end_fill1;
        end_written = emit_a ? written_reg + CNT_W'(end_fill2) : written_reg;
        emit_b    = end_written < region_size_reg;
        size_line = {TAIL_W'(end_written), {(LINE_W-TAIL_W){1'b0}}};

        case (in_req_reg)
            REQ_START: begin
                line_next    = '0;
                fill_next    = '0;
                written_next = '0;
                stopped_next = 1'b0;
            end
            REQ_DATA: begin
                if (!stopped_reg && elem_cnt != 3'd0) begin
                    if (stop_hit) begin
                        line_next    = {TAIL_TRUNC, line_reg[LINE_W-TAIL_W-1:0]};
                        fill_next    = FILL_W'(LINE_BYTES);
                        stopped_next = 1'b1;
                    end else if (fill_sum >= (FILL_W+1)'(LINE_BYTES)) begin
                        ld_raw.valid = 1'b1;
                        ld_raw.lines = 2'd1;
                        ld_raw.addr0 = line_addr;
                        ld_line0     = full_line;
                        line_next    = wrap_line;
                        fill_next    = wrap_cnt[FILL_W-1:0];
                        written_next = written_reg + CNT_W'(LINE_BYTES);
                    end else begin
                        line_next = full_line;
                        fill_next = fill_sum[FILL_W-1:0];
                    end
                end
            end
            REQ_END: begin
                if (emit_a) begin
                    ld_raw.valid = 1'b1;
                    ld_raw.lines = emit_b ? 2'd2 : 2'd1;
                    ld_raw.addr0 = line_addr;
                    ld_raw.addr1 = size_addr;
                    ld_line0     = end_line2;
                    ld_line1     = size_line;
                end else if (emit_b) begin
                    ld_raw.valid = 1'b1;
                    ld_raw.lines = 2'd1;
                    ld_raw.addr0 = size_addr;
                    ld_line0     = size_line;
                end
                line_next    = '0;
                fill_next    = '0;
                written_next = end_written;
                stopped_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_comb begin
        ld       = ld_raw;
        ld.valid = ld_raw.valid && in_adv;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg    <= '0;
            fill_reg    <= '0;
            written_reg <= '0;
            stopped_reg <= 1'b0;
        end else if (in_adv) begin
            line_reg    <= line_next;
            fill_reg    <= fill_next;
            written_reg <= written_next;
            stopped_reg <= stopped_next;
        end
    end

    dlp_line_emit #(
        .LINE_BYTES (LINE_BYTES)
    ) u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ld       (ld),
        .ld_line0 (ld_line0),
        .ld_line1 (ld_line1),
        .busy     (emit_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(LINE_BYTES))
        else $error("line fill beyond line size");

    a_stopped_full: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |-> fill_reg == FILL_W'(LINE_BYTES))
        else $error("stopped with partial line");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && emit_busy && ld_raw.valid))
        else $error("input stalled without a pending line");

endmodule
